### hdl/mns_pkg.sv
// Shared types and constants for the melody note sequencer.
package mns_pkg;

  // Sequencer states of the per-tick work
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAY,
    ST_FETCH,
    ST_DIV_LEN,
    ST_LEN,
    ST_TONE_SETUP,
    ST_DIV_TONE,
    ST_FINISH
  } state_t;

  // Command codes carried with each tick
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_PLAY,
    CMD_STOP,
    CMD_WRITE
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_WHOLE_NOTE,
    REG_DEBOUNCE,
    REG_SLOT0_START,
    REG_SLOT0_COUNT,
    REG_SLOT1_START,
    REG_SLOT1_COUNT,
    REG_SLOT2_START,
    REG_SLOT2_COUNT
  } reg_index_t;

  // Port widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 32;
  localparam int IN_USER_W   = 4;
  localparam int OUT_DATA_W  = 40;

  // Table entry: pitch in the low 13 bits, signed divider above
  localparam int ENTRY_W = 20;

  localparam logic [1:0]  STOPPED_POS      = 2'd3;
  localparam logic [9:0]  PTR_MAX          = 10'd1023;
  localparam logic [15:0] WHOLE_NOTE_RESET = 16'd2105;
  localparam logic [7:0]  DEBOUNCE_RESET   = 8'd50;
  localparam logic [7:0]  TICKS_MAX        = 8'd255;
  // ceil(2^23 / 10): exact floor(x / 10) for x below 2^22 after a shift by 23
  localparam logic [19:0] TONE_RECIP       = 20'd838861;
  localparam logic [4:0]  DIV_STEPS        = 5'd20;

endpackage

### hdl/melody_note_sequencer_core.sv
// Top level of the melody note sequencer: debounce, note playback, shared divider.

// One input item is one millisecond tick; one result item comes back for each.
// A tick that fetches no note runs the accept, playback check and finish steps,
// and one that fetches a pair with a zero divider adds the fetch step. Any other
// fetch adds a registered table read and 20 steps of one shared restoring
// divider (whole note over divider magnitude) and a length step; a sounding
// note then adds a tone setup and a tone step, its tone length, nine times the
// length over ten, coming from a constant reciprocal multiply. The next item is
// accepted in the cycle after the result is loaded, and the block takes it while
// a result still waits on the output register; its finish step then holds until
// that register is free. The note table needs no clearing after reset; an entry
// read before it was written holds any value. TABLE_DEPTH must be a power of
// two; pointers and entry addresses wrap on its low bits.
module melody_note_sequencer_core #(
  parameter int SLOT_COUNT  = 3,
  parameter int TABLE_DEPTH = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [mns_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mns_pkg::CFG_DATA_W-1:0]  cfg_data,
  // tick input
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: button_level, entry_address, entry_pitch, entry_divider, zero fill
  input  logic [mns_pkg::IN_DATA_W-1:0]   s_tdata,
  // s_tuser: command, slot
  input  logic [mns_pkg::IN_USER_W-1:0]   s_tuser,
  // tick result
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: tone_on, tone_pitch, note_started, note_length_ms, is_playing,
  //          cycle_position, zero fill
  output logic [mns_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import mns_pkg::*;

  localparam int         ADDR_W     = $clog2(TABLE_DEPTH);
  localparam logic [1:0] SLOT_LIMIT = 2'(SLOT_COUNT);

  // configuration registers
  logic [15:0] whole_note_ms;
  logic [7:0]  debounce_ticks;
  logic [8:0]  slot_start [3];
  logic [9:0]  slot_count [3];

  // control state
  state_t      state, state_next;
  logic        active, active_next;
  logic [9:0]  note_pointer, note_pointer_next;
  logic [9:0]  note_end, note_end_next;
  logic [16:0] note_remaining, note_remaining_next;
  logic [16:0] tone_remaining, tone_remaining_next;
  logic [12:0] current_pitch, current_pitch_next;
  logic [7:0]  stable_ticks, stable_ticks_next;
  logic        last_level, last_level_next;
  logic        stable_level, stable_level_next;
  logic [1:0]  cycle_slot, cycle_slot_next;

  // per-tick payload and divider registers
  cmd_t        cmd_q;
  logic [1:0]  slot_q;
  logic [8:0]  addr_q;
  logic [12:0] pitch_in_q;
  logic [6:0]  div_in_q;
  logic        note_started, note_started_next;
  logic [16:0] note_length, note_length_next;
  logic        dotted, dotted_next;
  logic [6:0]  rem, rem_next;
  logic [19:0] quo, quo_next;
  logic [6:0]  divisor, divisor_next;
  logic [4:0]  step_cnt, step_cnt_next;
  logic [ENTRY_W-1:0] rd_data;

  logic [ENTRY_W-1:0] note_table [TABLE_DEPTH];

  // combinational helpers
  logic        accept;
  logic        out_free;
  logic        out_load;
  logic        level;
  logic [7:0]  ticks_upd;
  logic        qualified;
  logic [1:0]  cyc_step;
  logic [8:0]  press_start, cmd_start;
  logic [9:0]  press_count, cmd_count;
  logic [10:0] press_sum, cmd_sum;
  logic [16:0] nr_dec;
  logic [7:0]  trial;
  logic        trial_ge;
  logic [6:0]  rem_step;
  logic [19:0] quo_step;
  logic [6:0]  div_mag;
  logic [17:0] dotted_len;
  logic [16:0] len_val;
  logic [39:0] tone_prod;
  logic        tone_on;
  logic [9:0]  addr_ext;
  logic [OUT_DATA_W-1:0] out_word;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == ST_FINISH) && out_free;
  assign level    = s_tdata[0];
  assign addr_ext = {1'b0, addr_q};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      whole_note_ms  <= WHOLE_NOTE_RESET;
      debounce_ticks <= DEBOUNCE_RESET;
      slot_start     <= '{default: '0};
      slot_count     <= '{default: '0};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WHOLE_NOTE:  whole_note_ms  <= cfg_data;
        REG_DEBOUNCE:    debounce_ticks <= cfg_data[7:0];
        REG_SLOT0_START: slot_start[0]  <= cfg_data[8:0];
        REG_SLOT0_COUNT: slot_count[0]  <= cfg_data[9:0];
        REG_SLOT1_START: slot_start[1]  <= cfg_data[8:0];
        REG_SLOT1_COUNT: slot_count[1]  <= cfg_data[9:0];
        REG_SLOT2_START: slot_start[2]  <= cfg_data[8:0];
        REG_SLOT2_COUNT: slot_count[2]  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // debounce: updated stable count and next cycle position
  always_comb begin
    if (level != last_level) begin
      ticks_upd = '0;
    end else if (stable_ticks < TICKS_MAX) begin
      ticks_upd = stable_ticks + 8'd1;
    end else begin
      ticks_upd = stable_ticks;
    end
    qualified = (ticks_upd >= debounce_ticks);
    cyc_step  = (cycle_slot == STOPPED_POS) ? 2'd0 : cycle_slot + 2'd1;
  end

  // slot range of a button press
  always_comb begin
    case (cyc_step)
      2'd0: begin
        press_start = slot_start[0];
        press_count = slot_count[0];
      end
      2'd1: begin
        press_start = slot_start[1];
        press_count = slot_count[1];
      end
      2'd2: begin
        press_start = slot_start[2];
        press_count = slot_count[2];
      end
      default: begin
        press_start = '0;
        press_count = '0;
      end
    endcase
    press_sum = {2'b00, press_start} + {1'b0, press_count};
  end

  // slot range of a play command
  always_comb begin
    case (slot_q)
      2'd0: begin
        cmd_start = slot_start[0];
        cmd_count = slot_count[0];
      end
      2'd1: begin
        cmd_start = slot_start[1];
        cmd_count = slot_count[1];
      end
      2'd2: begin
        cmd_start = slot_start[2];
        cmd_count = slot_count[2];
      end
      default: begin
        cmd_start = '0;
        cmd_count = '0;
      end
    endcase
    cmd_sum = {2'b00, cmd_start} + {1'b0, cmd_count};
  end

  // shared divider step: one restoring quotient bit per cycle
  always_comb begin
    trial    = {rem, quo[19]};
    trial_ge = (trial >= {1'b0, divisor});
    rem_step = trial_ge ? 7'(trial - {1'b0, divisor}) : trial[6:0];
    quo_step = {quo[18:0], trial_ge};
  end

  // note length from the divider pass, times 3/2 when dotted
  assign nr_dec     = (note_remaining != '0) ? note_remaining - 17'd1 : '0;
  assign div_mag    = rd_data[19] ? 7'(~rd_data[19:13] + 7'd1) : rd_data[19:13];
  assign dotted_len = {1'b0, quo[16:0]} + {quo[16:0], 1'b0};
  assign len_val    = dotted ? dotted_len[17:1] : quo[16:0];

  // nine times the length (held in quo) over ten by reciprocal multiply
  assign tone_prod  = quo * TONE_RECIP;

  // sequencer: next state and register updates
  always_comb begin
    state_next          = state;
    active_next         = active;
    note_pointer_next   = note_pointer;
    note_end_next       = note_end;
    note_remaining_next = note_remaining;
    tone_remaining_next = tone_remaining;
    current_pitch_next  = current_pitch;
    stable_ticks_next   = stable_ticks;
    last_level_next     = last_level;
    stable_level_next   = stable_level;
    cycle_slot_next     = cycle_slot;
    note_started_next   = note_started;
    note_length_next    = note_length;
    dotted_next         = dotted;
    rem_next            = rem;
    quo_next            = quo;
    divisor_next        = divisor;
    step_cnt_next       = step_cnt;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          tone_remaining_next = (tone_remaining != '0) ? tone_remaining - 17'd1 : '0;
          stable_ticks_next   = ticks_upd;
          last_level_next     = level;
          note_started_next   = 1'b0;
          note_length_next    = '0;
          if (qualified && !level && stable_level) begin
            stable_level_next = 1'b0;
            if (cyc_step < SLOT_LIMIT) begin
              cycle_slot_next     = cyc_step;
              active_next         = 1'b1;
              note_pointer_next   = {1'b0, press_start};
              note_end_next       = press_sum[10] ? PTR_MAX : press_sum[9:0];
              note_remaining_next = '0;
            end else begin
              cycle_slot_next     = STOPPED_POS;
              active_next         = 1'b0;
              tone_remaining_next = '0;
            end
          end else if (qualified && level) begin
            stable_level_next = 1'b1;
          end
          state_next = ST_PLAY;
        end
      end

      ST_PLAY: begin
        state_next = ST_FINISH;
        if (active) begin
          note_remaining_next = nr_dec;
          if (nr_dec == '0) begin
            if (note_pointer >= note_end) begin
              active_next         = 1'b0;
              tone_remaining_next = '0;
            end else begin
              note_pointer_next = note_pointer + 10'd1;
              state_next        = ST_FETCH;
            end
          end
        end
      end

      ST_FETCH: begin
        current_pitch_next = rd_data[12:0];
        note_started_next  = 1'b1;
        if (rd_data[19:13] == '0) begin
          note_length_next    = '0;
          note_remaining_next = '0;
          tone_remaining_next = '0;
          state_next          = ST_FINISH;
        end else begin
          dotted_next   = rd_data[19];
          quo_next      = {4'b0000, whole_note_ms};
          rem_next      = '0;
          divisor_next  = div_mag;
          step_cnt_next = '0;
          state_next    = ST_DIV_LEN;
        end
      end

      ST_DIV_LEN: begin
        rem_next      = rem_step;
        quo_next      = quo_step;
        step_cnt_next = step_cnt + 5'd1;
        if (step_cnt == DIV_STEPS - 5'd1) begin
          state_next = ST_LEN;
        end
      end

      ST_LEN: begin
        note_length_next    = len_val;
        note_remaining_next = len_val;
        if (current_pitch == '0) begin
          tone_remaining_next = '0;
          state_next          = ST_FINISH;
        end else begin
          state_next = ST_TONE_SETUP;
        end
      end

      ST_TONE_SETUP: begin
        // nine times the length, then over ten
        quo_next   = {note_length, 3'b000} + {3'b000, note_length};
        state_next = ST_DIV_TONE;
      end

      ST_DIV_TONE: begin
        tone_remaining_next = tone_prod[39:23];
        state_next          = ST_FINISH;
      end

      ST_FINISH: begin
        if (out_free) begin
          case (cmd_q)
            CMD_PLAY: begin
              if (slot_q < SLOT_LIMIT) begin
                active_next         = 1'b1;
                note_pointer_next   = {1'b0, cmd_start};
                note_end_next       = cmd_sum[10] ? PTR_MAX : cmd_sum[9:0];
                note_remaining_next = '0;
              end
            end
            CMD_STOP: begin
              active_next         = 1'b0;
              tone_remaining_next = '0;
            end
            default: ;
          endcase
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // result word after this tick's command
  always_comb begin
    tone_on  = (tone_remaining_next != '0);
    out_word = {5'b00000, cycle_slot, active_next, note_length, note_started,
                tone_on ? current_pitch : 13'd0, tone_on};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      active         <= 1'b0;
      note_pointer   <= '0;
      note_end       <= '0;
      note_remaining <= '0;
      tone_remaining <= '0;
      current_pitch  <= '0;
      stable_ticks   <= '0;
      last_level     <= 1'b1;
      stable_level   <= 1'b1;
      cycle_slot     <= STOPPED_POS;
      m_tvalid       <= 1'b0;
    end else begin
      state          <= state_next;
      active         <= active_next;
      note_pointer   <= note_pointer_next;
      note_end       <= note_end_next;
      note_remaining <= note_remaining_next;
      tone_remaining <= tone_remaining_next;
      current_pitch  <= current_pitch_next;
      stable_ticks   <= stable_ticks_next;
      last_level     <= last_level_next;
      stable_level   <= stable_level_next;
      cycle_slot     <= cycle_slot_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload and divider registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= cmd_t'(s_tuser[1:0]);
      slot_q     <= s_tuser[3:2];
      addr_q     <= s_tdata[9:1];
      pitch_in_q <= s_tdata[22:10];
      div_in_q   <= s_tdata[29:23];
    end
    note_started <= note_started_next;
    note_length  <= note_length_next;
    dotted       <= dotted_next;
    rem          <= rem_next;
    quo          <= quo_next;
    divisor      <= divisor_next;
    step_cnt     <= step_cnt_next;
    if (out_load) begin
      m_tdata <= out_word;
    end
  end

  // note table: read during the playback check, written by the command
  always_ff @(posedge clk) begin
    if (state == ST_PLAY) begin
      rd_data <= note_table[note_pointer[ADDR_W-1:0]];
    end
    if (out_load && cmd_q == CMD_WRITE) begin
      note_table[addr_ext[ADDR_W-1:0]] <= {div_in_q, pitch_in_q};
    end
  end

endmodule

### hdl/mns_checker.sv
// Port-level assertions for the melody note sequencer, bound to the top level.
module mns_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [mns_pkg::OUT_DATA_W-1:0] m_tdata
);
  import mns_pkg::*;

  logic [12:0] res_pitch;

  assign res_pitch = m_tdata[13:1];

  // no result item right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // a sounding tone has a nonzero pitch, a silent one reports zero
  a_pitch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (res_pitch != '0)))
    else $error("tone pitch does not match tone gate");

  // no tone while playback is idle
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[32] |-> !m_tdata[0])
    else $error("tone on while not playing");

  // the output word's unused top bits stay zero
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:35] == '0)
    else $error("result fill bits set");

endmodule

bind melody_note_sequencer_core mns_checker u_mns_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### dv/tb.sv
// Self-checking testbench for the melody note sequencer core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mns_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int SLOTS       = 3;
  localparam int DEPTH       = 512;
  localparam int SETTLE      = 4;
  localparam int TAIL        = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int ITEM_TARGET = 1900;
  localparam int REPORT_MAX  = 100;

  // One tick as offered on the input stream
  typedef struct packed {
    logic       level;
    cmd_t       cmd;
    logic [1:0] slot;
    logic [8:0] addr;
    logic [12:0] pitch;
    logic [6:0] div;
  } tick_t;

  // One tick result, laid out as m_tdata[34:0]
  typedef struct packed {
    logic [1:0]  pos;
    logic        playing;
    logic [16:0] len;
    logic        started;
    logic [12:0] pitch;
    logic        tone_on;
  } tick_result_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata   = '0;
  logic [IN_USER_W-1:0]   s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;

  melody_note_sequencer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Pending ticks and results still due
  tick_t        ticks_pending [$];
  tick_result_t results_due [$];

  int ticks_queued = 0;
  int ticks_sent   = 0;
  int results_seen = 0;
  int notes_seen   = 0;
  int tones_seen   = 0;
  int setups       = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;
  logic btn = 1'b1;

  // ---------------------------------------------------------------------------
  // Sequencer image: note table, playback, debounce and register copies
  logic [19:0] note_mem [DEPTH];
  logic        pb_active    = 1'b0;
  logic [9:0]  pb_ptr       = '0;
  logic [9:0]  pb_end       = '0;
  logic [16:0] pb_note_left = '0;
  logic [16:0] pb_tone_left = '0;
  logic [12:0] pb_pitch     = '0;
  logic [7:0]  db_count     = '0;
  logic        db_last      = 1'b1;
  logic        db_stable    = 1'b1;
  logic [1:0]  cyc_pos      = STOPPED_POS;
  logic [15:0] whole_ms     = WHOLE_NOTE_RESET;
  logic [7:0]  deb_ms       = DEBOUNCE_RESET;
  logic [8:0]  slot_first [SLOTS] = '{default: '0};
  logic [9:0]  slot_len   [SLOTS] = '{default: '0};

  function automatic void start_slot(int s);
    int unsigned e;
    e = slot_first[s] + slot_len[s];
    pb_active    = 1'b1;
    pb_ptr       = slot_first[s];
    pb_end       = (e > 1023) ? 10'd1023 : e[9:0];
    pb_note_left = '0;
  endfunction

  function automatic void stop_playback();
    pb_active    = 1'b0;
    pb_tone_left = '0;
  endfunction

  // Note length from a 7-bit signed divider; dotted for negative values
  function automatic int unsigned note_len(logic [6:0] d);
    int unsigned w = whole_ms;
    int unsigned mag;
    if (d == 0) return 0;
    if (d[6]) begin
      mag = 32'd128 - d;
      return ((w / mag) * 3) / 2;
    end
    return w / d;
  endfunction

  // Advance the image by one tick and return what the block must emit
  function automatic tick_result_t next_tick_result(tick_t t);
    tick_result_t r;
    logic [19:0] e;
    int unsigned len;
    int unsigned nxt;
    r   = '0;
    len = 0;
    if (pb_tone_left != 0) pb_tone_left--;

    // debounce
    if (t.level != db_last) begin
      db_count = '0;
      db_last  = t.level;
    end else if (db_count < TICKS_MAX) begin
      db_count++;
    end
    if (db_count >= deb_ms) begin
      if (!t.level && db_stable) begin
        nxt       = (cyc_pos == STOPPED_POS) ? 0 : cyc_pos + 1;
        db_stable = 1'b0;
        if (nxt < SLOTS) begin
          cyc_pos = nxt[1:0];
          start_slot(nxt);
        end else begin
          cyc_pos = STOPPED_POS;
          stop_playback();
        end
      end else if (t.level) begin
        db_stable = 1'b1;
      end
    end

    // playback
    if (pb_active) begin
      if (pb_note_left != 0) pb_note_left--;
      if (pb_note_left == 0) begin
        if (pb_ptr >= pb_end) begin
          stop_playback();
        end else begin
          e            = note_mem[pb_ptr[8:0]];
          pb_ptr++;
          len          = note_len(e[19:13]);
          r.started    = 1'b1;
          pb_note_left = len[16:0];
          pb_pitch     = e[12:0];
          pb_tone_left = (e[12:0] == 0) ? 17'd0 : 17'((len * 9) / 10);
        end
      end
    end

    // command
    case (t.cmd)
      CMD_PLAY:  if (t.slot < SLOTS) start_slot(t.slot);
      CMD_STOP:  stop_playback();
      CMD_WRITE: note_mem[t.addr] = {t.div, t.pitch};
      default: ;
    endcase

    r.tone_on = (pb_tone_left != 0);
    r.pitch   = r.tone_on ? pb_pitch : 13'd0;
    r.len     = len[16:0];
    r.playing = pb_active;
    r.pos     = cyc_pos;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Per-item idle draw: spans of random gaps mix at random with spans of none
  function automatic int draw_gap(inout int span, inout bit calm);
    if (span == 0) begin
      span = $urandom_range(80, 20);
      calm = ($urandom_range(3) == 0);
    end
    span--;
    return calm ? 0 : $urandom_range(14);
  endfunction

  // Tick driver
  tick_t drv_item = '0;
  int    drv_wait = 0;
  int    drv_span = 0;
  bit    drv_calm = 1'b0;

  always @(posedge clk) begin : driver
    logic busy;
    if (rst) begin
      s_tvalid <= 1'b0;
      drv_wait = 0;
    end else begin
      busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        results_due.push_back(next_tick_result(drv_item));
        ticks_sent++;
        busy     = 1'b0;
        drv_wait = draw_gap(drv_span, drv_calm);
      end
      if (!busy) begin
        if (drv_wait > 0) begin
          drv_wait--;
        end else if (ticks_pending.size() != 0) begin
          drv_item = ticks_pending.pop_front();
          busy     = 1'b1;
        end
      end
      s_tvalid <= busy;
      s_tdata  <= {2'b00, drv_item.div, drv_item.pitch, drv_item.addr, drv_item.level};
      s_tuser  <= {drv_item.slot, drv_item.cmd};
    end
  end

  // Result monitor and checker
  int mon_wait   = 0;
  int mon_span   = 0;
  bit mon_calm   = 1'b0;
  int hold_left  = 0;
  int hold_token = 0;
  int hold_seen  = 0;

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $error("result %0d %s: expected %0d, got %0d", results_seen, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    tick_result_t want, got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = tick_result_t'(m_tdata[34:0]);
        if (results_due.size() == 0) begin
          mismatches++;
          $error("result %0d arrived with nothing expected: %h", results_seen, m_tdata);
        end else begin
          want = results_due.pop_front();
          check_field("tone_on", want.tone_on, got.tone_on);
          check_field("tone_pitch", want.pitch, got.pitch);
          check_field("note_started", want.started, got.started);
          check_field("note_length_ms", want.len, got.len);
          check_field("is_playing", want.playing, got.playing);
          check_field("cycle_position", want.pos, got.pos);
          notes_seen += want.started;
          tones_seen += want.tone_on;
        end
        results_seen++;
        mon_wait = draw_gap(mon_span, mon_calm);
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (mon_wait > 0) begin
        mon_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  function automatic logic [6:0] div_code(int v);
    return v[6:0];
  endfunction

  function automatic logic [6:0] rand_div();
    return div_code(int'($urandom_range(64)) - 32);
  endfunction

  function automatic logic [12:0] rand_pitch();
    return ($urandom_range(7) == 0) ? 13'd0 : 13'($urandom_range(8191));
  endfunction

  function automatic void push_tick(logic lvl, cmd_t c, logic [1:0] sl, logic [8:0] a,
                                    logic [12:0] p, logic [6:0] d);
    tick_t t;
    t.level = lvl;
    t.cmd   = c;
    t.slot  = sl;
    t.addr  = a;
    t.pitch = p;
    t.div   = d;
    ticks_pending.push_back(t);
    ticks_queued++;
  endfunction

  // Command with random filler in the fields it does not use
  function automatic void push_cmd(cmd_t c, logic [1:0] sl);
    push_tick(btn, c, sl, 9'($urandom_range(511)), 13'($urandom), rand_div());
  endfunction

  function automatic void push_write(logic [8:0] a, logic [12:0] p, logic [6:0] d);
    push_tick(btn, CMD_WRITE, 2'($urandom_range(3)), a, p, d);
  endfunction

  function automatic void push_quiet(int n);
    repeat (n) push_cmd(CMD_NONE, 2'($urandom_range(3)));
  endfunction

  function automatic void push_level(logic lvl, int n);
    btn = lvl;
    push_quiet(n);
  endfunction

  // One short sequence of a given kind; random content throughout
  function automatic void add_segment(int kind);
    case (kind)
      0, 1, 2, 3: begin
        push_cmd(CMD_PLAY, 2'($urandom_range(3)));
        push_quiet($urandom_range(25, 2));
      end
      4: begin
        push_cmd(CMD_STOP, 2'($urandom_range(3)));
        push_quiet($urandom_range(3));
      end
      5, 6: begin
        // clean press then clean release
        push_level(1'b0, deb_ms + $urandom_range(3, 1));
        push_level(1'b1, deb_ms + $urandom_range(3, 1));
      end
      7: push_write(9'($urandom_range(511)), rand_pitch(), rand_div());
      8: begin
        // contact bounce
        repeat ($urandom_range(8, 2)) push_level(1'($urandom_range(1)), 1);
      end
      9: begin
        repeat ($urandom_range(4, 1))
          push_tick(1'($urandom_range(1)), cmd_t'($urandom_range(3)),
                    2'($urandom_range(3)), 9'($urandom_range(511)), 13'($urandom),
                    rand_div());
      end
      default: push_quiet($urandom_range(10, 1));
    endcase
  endfunction

  function automatic void add_segments(int n);
    repeat (n) add_segment($urandom_range(11));
  endfunction

  // Wait until no tick is pending, in flight or unanswered
  task automatic wait_drained();
    @(negedge clk);
    while (ticks_pending.size() != 0 || s_tvalid || results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WHOLE_NOTE:  whole_ms      = val;
      REG_DEBOUNCE:    deb_ms        = val[7:0];
      REG_SLOT0_START: slot_first[0] = val[8:0];
      REG_SLOT0_COUNT: slot_len[0]   = val[9:0];
      REG_SLOT1_START: slot_first[1] = val[8:0];
      REG_SLOT1_COUNT: slot_len[1]   = val[9:0];
      REG_SLOT2_START: slot_first[2] = val[8:0];
      REG_SLOT2_COUNT: slot_len[2]   = val[9:0];
      default: ;
    endcase
  endtask

  task automatic load_setup(logic [15:0] whole, logic [7:0] deb,
                            logic [8:0] st0, logic [9:0] ct0,
                            logic [8:0] st1, logic [9:0] ct1,
                            logic [8:0] st2, logic [9:0] ct2);
    write_reg(REG_WHOLE_NOTE, whole);
    write_reg(REG_DEBOUNCE, {8'd0, deb});
    write_reg(REG_SLOT0_START, {7'd0, st0});
    write_reg(REG_SLOT0_COUNT, {6'd0, ct0});
    write_reg(REG_SLOT1_START, {7'd0, st1});
    write_reg(REG_SLOT1_COUNT, {6'd0, ct1});
    write_reg(REG_SLOT2_START, {7'd0, st2});
    write_reg(REG_SLOT2_COUNT, {6'd0, ct2});
    setups++;
    @(negedge clk);
  endtask

  function automatic logic [9:0] rand_count();
    case ($urandom_range(7))
      0:       return 10'd512;
      1:       return 10'd0;
      default: return 10'($urandom_range(12, 1));
    endcase
  endfunction

  function automatic logic [15:0] rand_whole();
    case ($urandom_range(7))
      0:       return 16'($urandom_range(65535));
      1:       return 16'($urandom_range(4000, 1000));
      default: return 16'($urandom_range(48, 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  initial begin : stimulus
    int p;
    int k;
    int far_divs [5];
    logic [8:0] st0;
    far_divs = '{-1, 1, -32, 32, 0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: a few entries around the table wrap, slots kept inside them
    load_setup(16'd16, 8'd2, 9'd510, 10'd4, 9'd2, 10'd2, 9'd3, 10'd1);
    push_write(9'd510, 13'd8191, div_code(4));
    push_write(9'd511, 13'd0, div_code(-8));
    push_write(9'd0, 13'd1, div_code(0));
    push_write(9'd1, 13'd4096, div_code(32));
    push_write(9'd2, 13'd100, div_code(16));
    push_write(9'd3, 13'd200, div_code(-1));
    push_cmd(CMD_PLAY, 2'd0);
    push_quiet(10);
    push_cmd(CMD_PLAY, 2'd3);
    push_cmd(CMD_PLAY, 2'd1);
    push_quiet(2);
    push_cmd(CMD_STOP, 2'd0);
    push_level(1'b0, 3);
    push_level(1'b1, 3);
    push_cmd(CMD_STOP, 2'd1);

    // Fill the whole table so that any slot reads written entries only
    wait_drained();
    for (k = 0; k < DEPTH; k++) push_write(k[8:0], rand_pitch(), rand_div());

    p = 1;
    while (ticks_queued < ITEM_TARGET) begin
      wait_drained();
      case (p)
        1: begin
          // longest notes, widest slots, end pointer saturating
          st0 = 9'($urandom_range(511));
          load_setup(16'hFFFF, 8'd1, st0, 10'd512, 9'($urandom_range(511)), 10'd1,
                     9'd511, 10'd1023);
          foreach (far_divs[i]) begin
            push_write(st0, 13'd8191, div_code(far_divs[i]));
            push_cmd(CMD_PLAY, 2'd0);
            push_quiet(2);
            push_cmd(CMD_STOP, 2'd0);
          end
          push_write(9'd511, 13'd8191, div_code(-1));
          push_cmd(CMD_PLAY, 2'd2);
          push_quiet(2);
          push_cmd(CMD_STOP, 2'd2);
          add_segments(8);
        end
        2: begin
          // zero whole note and zero debounce
          load_setup(16'd0, 8'd0, 9'($urandom_range(511)), rand_count(), 9'd0, 10'd512,
                     9'd511, 10'd1023);
          add_segments(12);
        end
        3: begin
          // slowest debounce: one full press and release
          load_setup(rand_whole(), 8'd255, 9'($urandom_range(511)), rand_count(),
                     9'($urandom_range(511)), rand_count(), 9'($urandom_range(511)),
                     rand_count());
          add_segment(5);
          add_segment(0);
          add_segment(4);
        end
        4: begin
          // shortest whole note, receiver stalls long while ticks keep coming
          load_setup(16'd1, 8'($urandom_range(4, 1)), 9'($urandom_range(511)), rand_count(),
                     9'($urandom_range(511)), rand_count(), 9'($urandom_range(511)),
                     rand_count());
          hold_token <= hold_token + 1;
          add_segments(12);
        end
        default: begin
          load_setup(rand_whole(), 8'($urandom_range(6)), 9'($urandom_range(511)),
                     rand_count(), 9'($urandom_range(511)), rand_count(),
                     9'($urandom_range(511)), rand_count());
          add_segments(12);
        end
      endcase
      p++;
    end

    wait_drained();
    repeat (TAIL) @(negedge clk);
    if (results_due.size() != 0) begin
      mismatches++;
      $error("%0d expected results never arrived", results_due.size());
    end
    $display("Ran %0d ticks under %0d register setups, %0d results checked",
             ticks_sent, setups, results_seen);
    $display("Saw %0d note fetches and %0d sounding ticks, %0d mismatches",
             notes_seen, tones_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
